/* src/mserc_pkg.sv */
// ----------------------------------------------------------------------------
// mserc_pkg: shared definitions for the multi-scale event rate counter
// Ring sizes, field widths, operation codes and the gap helper.
// ----------------------------------------------------------------------------
package mserc_pkg;

    localparam int SEC_SLOTS = 60;
    localparam int MIN_SLOTS = 60;
    localparam int HR_SLOTS  = 24;

    // counters and span-wide values hold any ring length up to 63
    localparam int SLOT_W = 6;
    localparam int SEC_AW = $clog2(SEC_SLOTS);
    localparam int MIN_AW = $clog2(MIN_SLOTS);
    localparam int HR_AW  = $clog2(HR_SLOTS);
    localparam int MAX_SLOTS = (SEC_SLOTS > MIN_SLOTS)
        ? ((SEC_SLOTS > HR_SLOTS) ? SEC_SLOTS : HR_SLOTS)
        : ((MIN_SLOTS > HR_SLOTS) ? MIN_SLOTS : HR_SLOTS);

    localparam int OP_W     = 2;
    localparam int TS_W     = 31;
    localparam int SPAN_W   = 6;
    localparam int TOTAL_W  = 38;
    localparam int BUCKET_W = 32;
    localparam int MIN_W    = 26;
    localparam int HR_W     = 20;

    // floor(n / 60) = (n * RECIP60) >> DIV_SHIFT for any 31-bit n
    localparam logic [31:0] RECIP60   = 32'd2290649225;
    localparam int          DIV_SHIFT = 37;
    localparam int          PROD_W    = TS_W + 32;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_SEC    = 2'd1,
        OP_MIN    = 2'd2,
        OP_HR     = 2'd3
    } t_op;

    // number of zero buckets to shift in, capped at the ring length
    function automatic logic [SLOT_W-1:0] zero_count(
        input logic [TS_W-1:0]   new_unit,
        input logic [TS_W-1:0]   old_unit,
        input logic [SLOT_W-1:0] slots
    );
        logic [TS_W-1:0] gap;
        gap = new_unit - old_unit;
        if (new_unit <= old_unit) begin
            zero_count = '0;
        end else if (gap >= TS_W'(slots)) begin
            zero_count = slots;
        end else begin
            zero_count = gap[SLOT_W-1:0];
        end
    endfunction

endpackage

/* src/multi_scale_event_rate_counter.sv */
// ----------------------------------------------------------------------------
// multi_scale_event_rate_counter
// Event counts over three bucket rings: seconds, minutes and hours.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes one word: a record of an event at
// i_timestamp, or a query for the i_span newest buckets of one ring. The
// output channel (o_valid / i_ready) returns one word per query: the sum in
// o_total, or o_span_error when the span is longer than the ring.
// Each ring is a circular buffer with a head pointer. A record runs the new
// time through one shared multiplier twice (divide by 60, then by 60 again),
// then zeroes the skipped buckets, capped at the ring length, one per cycle in
// all rings at once, then does a read-modify-write of the newest buckets.
// A query reads one bucket per cycle through the ring's registered read port;
// an empty or oversized span reads nothing.
// o_ready is high only between items. The result sits in an output register,
// so a new item is taken while a result still waits; a query that finishes
// while the receiver stalls holds until the register frees up.
// After reset the block sweeps zeros into the rings (one entry per cycle)
// with o_ready low.
// ----------------------------------------------------------------------------
module multi_scale_event_rate_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mserc_pkg::OP_W-1:0]      i_operation,
    input  logic [mserc_pkg::TS_W-1:0]      i_timestamp,
    input  logic [mserc_pkg::SPAN_W-1:0]    i_span,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mserc_pkg::TOTAL_W-1:0]   o_total,
    output logic                            o_span_error
);
    import mserc_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DIV1   = 9'b000000100,
        S_DIV2   = 9'b000001000,
        S_GAP    = 9'b000010000,
        S_ADV    = 9'b000100000,
        S_INC_RD = 9'b001000000,
        S_INC_WR = 9'b010000000,
        S_SUM    = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_step;
    t_op                   r_op;
    logic [TS_W-1:0]       r_ts;
    logic [TS_W-1:0]       r_last_sec;
    logic [MIN_W-1:0]      r_last_min, r_new_min;
    logic [HR_W-1:0]       r_last_hr, r_new_hr;
    logic [SLOT_W-1:0]     r_z_sec, r_z_min, r_z_hr;
    logic [SEC_AW-1:0]     r_sec_head;
    logic [MIN_AW-1:0]     r_min_head;
    logic [HR_AW-1:0]      r_hr_head;
    logic [SLOT_W-1:0]     r_addr, r_left;
    logic                  r_pend;
    logic                  r_done;
    logic [TOTAL_W-1:0]    r_acc;
    logic                  r_err;
    logic                  r_out_valid;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_out_err;

    logic [BUCKET_W-1:0]   r_sec_mem [SEC_SLOTS];
    logic [BUCKET_W-1:0]   r_min_mem [MIN_SLOTS];
    logic [BUCKET_W-1:0]   r_hr_mem  [HR_SLOTS];
    logic [BUCKET_W-1:0]   r_sec_rd, r_min_rd, r_hr_rd;

    logic                  sec_we, min_we, hr_we;
    logic [SEC_AW-1:0]     sec_waddr, sec_raddr, sec_head_nxt;
    logic [MIN_AW-1:0]     min_waddr, min_raddr, min_head_nxt;
    logic [HR_AW-1:0]      hr_waddr, hr_raddr, hr_head_nxt;
    logic [BUCKET_W-1:0]   sec_wdata, min_wdata, hr_wdata;

    t_op                   op_sel;
    logic [SLOT_W-1:0]     sel_slots, sel_head;
    logic [BUCKET_W-1:0]   sel_rd;
    logic [TS_W-1:0]       mul_a;
    logic [PROD_W-1:0]     prod;
    logic [MIN_W-1:0]      quot;
    logic [SLOT_W:0]       step_inc;
    logic                  adv_done;
    logic                  out_free;
    logic                  in_fire;

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_total      = r_total;
    assign o_span_error = r_out_err;
    assign in_fire      = i_valid && o_ready;
    assign out_free     = !r_out_valid || i_ready;

    // shared divide-by-60 unit
    assign mul_a = (r_state == S_DIV1) ? r_ts : TS_W'(r_new_min);
    assign prod  = PROD_W'(mul_a) * PROD_W'(RECIP60);
    assign quot  = prod[PROD_W-1:DIV_SHIFT];

    assign sec_head_nxt = (r_sec_head == SEC_AW'(SEC_SLOTS - 1)) ? '0 : r_sec_head + 1'b1;
    assign min_head_nxt = (r_min_head == MIN_AW'(MIN_SLOTS - 1)) ? '0 : r_min_head + 1'b1;
    assign hr_head_nxt  = (r_hr_head == HR_AW'(HR_SLOTS - 1)) ? '0 : r_hr_head + 1'b1;

    assign step_inc = {1'b0, r_step} + 1'b1;
    assign adv_done = (step_inc >= {1'b0, r_z_sec}) && (step_inc >= {1'b0, r_z_min})
                   && (step_inc >= {1'b0, r_z_hr});

    assign op_sel = (r_state == S_IDLE) ? t_op'(i_operation) : r_op;

    always_comb begin
        sel_slots = SLOT_W'(HR_SLOTS);
        sel_head  = SLOT_W'(r_hr_head);
        sel_rd    = r_hr_rd;
        unique case (op_sel)
            OP_SEC: begin
                sel_slots = SLOT_W'(SEC_SLOTS);
                sel_head  = SLOT_W'(r_sec_head);
                sel_rd    = r_sec_rd;
            end
            OP_MIN: begin
                sel_slots = SLOT_W'(MIN_SLOTS);
                sel_head  = SLOT_W'(r_min_head);
                sel_rd    = r_min_rd;
            end
            default: begin
            end
        endcase
    end

    // ring write ports: clear sweep, zero shift-in, newest-bucket update
    always_comb begin
        sec_we    = 1'b0;
        min_we    = 1'b0;
        hr_we     = 1'b0;
        sec_waddr = r_sec_head;
        min_waddr = r_min_head;
        hr_waddr  = r_hr_head;
        sec_wdata = '0;
        min_wdata = '0;
        hr_wdata  = '0;
        unique case (r_state)
            S_CLEAR: begin
                sec_we    = (r_step < SLOT_W'(SEC_SLOTS));
                min_we    = (r_step < SLOT_W'(MIN_SLOTS));
                hr_we     = (r_step < SLOT_W'(HR_SLOTS));
                sec_waddr = r_step[SEC_AW-1:0];
                min_waddr = r_step[MIN_AW-1:0];
                hr_waddr  = r_step[HR_AW-1:0];
            end
            S_ADV: begin
                sec_we    = (r_step < r_z_sec);
                min_we    = (r_step < r_z_min);
                hr_we     = (r_step < r_z_hr);
                sec_waddr = sec_head_nxt;
                min_waddr = min_head_nxt;
                hr_waddr  = hr_head_nxt;
            end
            S_INC_WR: begin
                sec_we    = 1'b1;
                min_we    = 1'b1;
                hr_we     = 1'b1;
                sec_wdata = (&r_sec_rd) ? r_sec_rd : r_sec_rd + 1'b1;
                min_wdata = (&r_min_rd) ? r_min_rd : r_min_rd + 1'b1;
                hr_wdata  = (&r_hr_rd) ? r_hr_rd : r_hr_rd + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sec_raddr = (r_state == S_SUM && r_op == OP_SEC) ? r_addr[SEC_AW-1:0] : r_sec_head;
    assign min_raddr = (r_state == S_SUM && r_op == OP_MIN) ? r_addr[MIN_AW-1:0] : r_min_head;
    assign hr_raddr  = (r_state == S_SUM && r_op == OP_HR) ? r_addr[HR_AW-1:0] : r_hr_head;

    always_ff @(posedge i_clk) begin
        if (sec_we) begin
            r_sec_mem[sec_waddr] <= sec_wdata;
        end
        if (min_we) begin
            r_min_mem[min_waddr] <= min_wdata;
        end
        if (hr_we) begin
            r_hr_mem[hr_waddr] <= hr_wdata;
        end
        r_sec_rd <= r_sec_mem[sec_raddr];
        r_min_rd <= r_min_mem[min_raddr];
        r_hr_rd  <= r_hr_mem[hr_raddr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_step == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (op_sel == OP_RECORD) begin
                        n_state = S_DIV1;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_DIV1:   n_state = S_DIV2;
            S_DIV2:   n_state = S_GAP;
            S_GAP:    n_state = S_ADV;
            S_ADV: begin
                if (adv_done) begin
                    n_state = S_INC_RD;
                end
            end
            S_INC_RD: n_state = S_INC_WR;
            S_INC_WR: n_state = S_IDLE;
            S_SUM: begin
                if (r_done && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_last_sec  <= '0;
            r_last_min  <= '0;
            r_last_hr   <= '0;
            r_sec_head  <= '0;
            r_min_head  <= '0;
            r_hr_head   <= '0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state <= n_state;
            // a finished query loads the output register, a taken word empties it
            if (r_state == S_SUM && r_done && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_step <= r_step + 1'b1;
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op   <= t_op'(i_operation);
                        r_ts   <= i_timestamp;
                        r_acc  <= '0;
                        r_pend <= 1'b0;
                        r_addr <= sel_head;
                        // oversized or empty spans finish with no reads
                        if (i_span > sel_slots) begin
                            r_err  <= 1'b1;
                            r_left <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_err  <= 1'b0;
                            r_left <= i_span;
                            r_done <= (i_span == '0);
                        end
                    end
                end
                S_DIV1: begin
                    r_new_min <= quot;
                    r_z_sec   <= zero_count(r_ts, r_last_sec, SLOT_W'(SEC_SLOTS));
                end
                S_DIV2: begin
                    r_new_hr <= quot[HR_W-1:0];
                    r_z_min  <= zero_count(TS_W'(r_new_min), TS_W'(r_last_min),
                                           SLOT_W'(MIN_SLOTS));
                end
                S_GAP: begin
                    r_z_hr     <= zero_count(TS_W'(r_new_hr), TS_W'(r_last_hr),
                                             SLOT_W'(HR_SLOTS));
                    r_last_sec <= r_ts;
                    r_last_min <= r_new_min;
                    r_last_hr  <= r_new_hr;
                    r_step     <= '0;
                end
                S_ADV: begin
                    if (sec_we) begin
                        r_sec_head <= sec_head_nxt;
                    end
                    if (min_we) begin
                        r_min_head <= min_head_nxt;
                    end
                    if (hr_we) begin
                        r_hr_head <= hr_head_nxt;
                    end
                    r_step <= r_step + 1'b1;
                end
                S_INC_RD, S_INC_WR: begin
                end
                S_SUM: begin
                    if (r_done) begin
                        if (out_free) begin
                            r_total   <= r_acc;
                            r_out_err <= r_err;
                        end
                    end else begin
                        // walk from newest to older buckets, one read per cycle
                        if (r_left != '0) begin
                            r_addr <= (r_addr == '0) ? sel_slots - 1'b1 : r_addr - 1'b1;
                            r_left <= r_left - 1'b1;
                        end
                        r_pend <= (r_left != '0);
                        if (r_pend) begin
                            r_acc <= r_acc + TOTAL_W'(sel_rd);
                        end
                        r_done <= r_pend && (r_left == '0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* src/mserc_checker.sv */
// ----------------------------------------------------------------------------
// mserc_checker: port-level checks for the event rate counter
// Watches the two channels of the top level and flags protocol or result slips.
// ----------------------------------------------------------------------------
module mserc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [mserc_pkg::TOTAL_W-1:0]   o_total,
    input logic                            o_span_error
);
    import mserc_pkg::*;

    // nothing comes out of a reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output valid or input ready right after reset");

    // an error word never carries a sum
    a_err_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_error |-> o_total == '0)
        else $error("span error with nonzero total");

    // one item at a time: an accepted word keeps the input closed next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after an accepted word");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_total) && $stable(o_span_error))
        else $error("stalled result changed");

endmodule

bind multi_scale_event_rate_counter mserc_checker u_mserc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_total      (o_total),
    .o_span_error (o_span_error)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for multi_scale_event_rate_counter
// Drives event records and ring queries over the valid/ready input channel,
// keeps its own copy of the three bucket rings, and checks every query total
// and span error that comes back. A directed table comes first, then a random
// stream of mostly forward-moving timestamps with jumps, rewinds and queries.
// ----------------------------------------------------------------------------
module tb;
    import mserc_pkg::*;

    localparam int SECS_PER_MIN   = 60;
    localparam int SECS_PER_HR    = 3600;
    localparam int RING_COUNT     = 3;
    localparam int RING_LEN [RING_COUNT] = '{SEC_SLOTS, MIN_SLOTS, HR_SLOTS};
    localparam int RANDOM_WORDS   = 1700;
    localparam int CALM_TAIL      = 200;
    localparam int LONG_STALL     = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTS     = 40;
    localparam logic [TS_W-1:0] TS_MAX = '1;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               span_err;
    } reply_t;

    typedef struct packed {
        t_op               op;
        logic [TS_W-1:0]   ts;
        logic [SPAN_W-1:0] span;
        bit                typed;
        reply_t            reply;
    } stim_row_t;

    localparam int DIR_N = 25;

    // typed replies only where the value is plain; the rest use the predictor
    stim_row_t directed_rows [DIR_N] = '{
        '{OP_SEC,    31'd0,  6'd60, 1'b1, '{38'd0, 1'b0}},  // empty rings
        '{OP_SEC,    31'd0,  6'd61, 1'b1, '{38'd0, 1'b1}},
        '{OP_MIN,    31'd0,  6'd63, 1'b1, '{38'd0, 1'b1}},
        '{OP_HR,     31'd0,  6'd24, 1'b1, '{38'd0, 1'b0}},
        '{OP_HR,     31'd0,  6'd25, 1'b1, '{38'd0, 1'b1}},
        '{OP_MIN,    31'd0,  6'd0,  1'b1, '{38'd0, 1'b0}},
        '{OP_RECORD, 31'd0,  6'd0,  1'b0, '{38'd0, 1'b0}},  // first event at time zero
        '{OP_SEC,    31'd0,  6'd1,  1'b1, '{38'd1, 1'b0}},
        '{OP_RECORD, 31'd7,  6'd63, 1'b0, '{38'd0, 1'b0}},
        '{OP_RECORD, 31'd7,  6'd0,  1'b0, '{38'd0, 1'b0}},  // same second
        '{OP_RECORD, 31'd3,  6'd0,  1'b0, '{38'd0, 1'b0}},  // time goes backwards
        '{OP_SEC,    31'd0,  6'd8,  1'b0, '{38'd0, 1'b0}},
        '{OP_MIN,    31'd0,  6'd1,  1'b0, '{38'd0, 1'b0}},
        '{OP_RECORD, 31'd125, 6'd0, 1'b0, '{38'd0, 1'b0}},
        '{OP_RECORD, 31'd3725, 6'd0, 1'b0, '{38'd0, 1'b0}},
        '{OP_SEC,    31'd0,  6'd60, 1'b0, '{38'd0, 1'b0}},
        '{OP_MIN,    31'd0,  6'd60, 1'b0, '{38'd0, 1'b0}},
        '{OP_HR,     31'd0,  6'd2,  1'b0, '{38'd0, 1'b0}},
        '{OP_RECORD, TS_MAX, 6'd0,  1'b0, '{38'd0, 1'b0}},  // jump clears all rings
        '{OP_SEC,    31'd0,  6'd63, 1'b1, '{38'd0, 1'b1}},
        '{OP_SEC,    31'd0,  6'd60, 1'b0, '{38'd0, 1'b0}},
        '{OP_HR,     31'd0,  6'd24, 1'b0, '{38'd0, 1'b0}},
        '{OP_RECORD, 31'd0,  6'd0,  1'b0, '{38'd0, 1'b0}},  // rewind to zero
        '{OP_HR,     31'd0,  6'd1,  1'b0, '{38'd0, 1'b0}},
        '{OP_MIN,    31'd0,  6'd61, 1'b1, '{38'd0, 1'b1}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [OP_W-1:0]      i_operation = '0;
    logic [TS_W-1:0]      i_timestamp = '0;
    logic [SPAN_W-1:0]    i_span = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [TOTAL_W-1:0]   o_total;
    logic                 o_span_error;

    multi_scale_event_rate_counter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_timestamp  (i_timestamp),
        .i_span       (i_span),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_total      (o_total),
        .o_span_error (o_span_error)
    );

    // bench copy of the rings, entry 0 is the newest bucket
    logic [BUCKET_W-1:0] bucket_ring [RING_COUNT][MAX_SLOTS];
    logic [TS_W-1:0]     last_stamp;
    reply_t              pending_replies [$];

    int  n_mismatch = 0;
    int  quiet_cycles = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  long_stall_req = 0;
    int  long_stall_seen = 0;
    int  rx_hold = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (n_mismatch < MAX_PRINTS) begin
            $display("tb: mismatch at %0t: %s", $time, msg);
        end
        n_mismatch++;
    endtask

    function automatic void record_event(input logic [TS_W-1:0] ts);
        int unsigned old_u [RING_COUNT];
        int unsigned new_u [RING_COUNT];
        int unsigned gap;
        int          g;
        old_u[0] = last_stamp;
        old_u[1] = last_stamp / SECS_PER_MIN;
        old_u[2] = last_stamp / SECS_PER_HR;
        new_u[0] = ts;
        new_u[1] = ts / SECS_PER_MIN;
        new_u[2] = ts / SECS_PER_HR;
        for (int r = 0; r < RING_COUNT; r++) begin
            if (new_u[r] > old_u[r]) begin
                gap = new_u[r] - old_u[r];
                if (gap >= RING_LEN[r]) begin
                    for (int i = 0; i < RING_LEN[r]; i++) bucket_ring[r][i] = '0;
                end else begin
                    g = int'(gap);
                    for (int i = RING_LEN[r] - 1; i >= g; i--) begin
                        bucket_ring[r][i] = bucket_ring[r][i-g];
                    end
                    for (int i = 0; i < g; i++) bucket_ring[r][i] = '0;
                end
            end
            // saturating count
            if (bucket_ring[r][0] != '1) begin
                bucket_ring[r][0] = bucket_ring[r][0] + 1'b1;
            end
        end
        last_stamp = ts;
    endfunction

    function automatic reply_t bucket_sum(input t_op op, input logic [SPAN_W-1:0] span);
        reply_t          r;
        int              ring;
        longint unsigned acc;
        ring = int'(op) - 1;
        acc  = 0;
        if (span > RING_LEN[ring]) begin
            r.total    = '0;
            r.span_err = 1'b1;
        end else begin
            for (int i = 0; i < int'(span); i++) acc += bucket_ring[ring][i];
            r.total    = acc[TOTAL_W-1:0];
            r.span_err = 1'b0;
        end
        return r;
    endfunction

    // offer one word, wait for it to be taken, then update the prediction
    task automatic send_word(input t_op op, input logic [TS_W-1:0] ts,
                             input logic [SPAN_W-1:0] span, input bit typed,
                             input reply_t typed_reply);
        int     gap;
        reply_t r;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_timestamp <= ts;
        i_span      <= span;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_RECORD) begin
            record_event(ts);
        end else begin
            r = bucket_sum(op, span);
            pending_replies.push_back(typed ? typed_reply : r);
        end
    endtask

    // receiver side: random stalls plus one long hold on request
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else if (long_stall_req != long_stall_seen) begin
            long_stall_seen <= long_stall_req;
            rx_hold <= LONG_STALL - 1;
            i_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_hold <= $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch($sformatf("unexpected word total=%0d err=%0b",
                                        o_total, o_span_error));
            end else begin
                want = pending_replies.pop_front();
                if (o_total !== want.total) begin
                    flag_mismatch($sformatf("total %0d, want %0d", o_total, want.total));
                end
                if (o_span_error !== want.span_err) begin
                    flag_mismatch($sformatf("span_error %0b, want %0b",
                                            o_span_error, want.span_err));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        longint unsigned cur_stamp;
        int              sel;
        int              step;
        t_op             op;
        logic [TS_W-1:0] ts;
        logic [SPAN_W-1:0] span;

        foreach (bucket_ring[r, i]) bucket_ring[r][i] = '0;
        last_stamp = '0;
        cur_stamp  = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].op, directed_rows[k].ts, directed_rows[k].span,
                      directed_rows[k].typed, directed_rows[k].reply);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n >= RANDOM_WORDS - CALM_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if (n % 150 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (n == 300) long_stall_req++;
            if (n == 800) begin
                // hold the input until every query answer is back
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_replies.size() != 0) @(negedge i_clk);
            end

            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                step = $urandom_range(0, 99);
                if (step < 30) begin
                    // same second
                end else if (step < 60) begin
                    cur_stamp += $urandom_range(1, 5);
                end else if (step < 75) begin
                    cur_stamp += $urandom_range(6, 120);
                end else if (step < 87) begin
                    cur_stamp += $urandom_range(60, 7200);
                end else if (step < 94) begin
                    cur_stamp += $urandom_range(3600, 200000);
                end else if (step < 97) begin
                    step = $urandom_range(1, 5000);
                    cur_stamp = (cur_stamp > step) ? cur_stamp - step : 0;
                end else begin
                    cur_stamp = $urandom & TS_MAX;
                end
                if (cur_stamp > TS_MAX) cur_stamp = $urandom_range(0, 1000);
                op   = OP_RECORD;
                ts   = cur_stamp[TS_W-1:0];
                span = SPAN_W'($urandom);
            end else begin
                op   = t_op'($urandom_range(1, 3));
                ts   = TS_W'($urandom);
                span = (sel < 92) ? SPAN_W'($urandom_range(0, RING_LEN[int'(op) - 1]))
                                  : SPAN_W'($urandom_range(0, 63));
            end
            send_word(op, ts, span, 1'b0, '0);
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
